FILE: sv/bitonic_sorter_core_macros.svh
// assertion macros for the bitonic sorter core
// expects signals named clock and reset in the module that uses them
`ifndef BITONIC_SORTER_CORE_MACROS_SVH
`define BITONIC_SORTER_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define BSC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bs_pkg.sv
// shared types and helpers for the bitonic sorter
// no dependencies
package bs_pkg;

   localparam int VALUE_W = 32;

   // stored element: pad marks a filler slot beyond the real set
   typedef struct packed {
      logic                      pad;
      logic signed [VALUE_W-1:0] value;
   } elem_type;

   localparam int ELEM_W = $bits(elem_type);

   // control for one compare-exchange
   typedef struct packed {
      logic up;         // this block runs ascending
      logic ascending;  // final order, decides where fillers sort
   } xchg_ctrl_type;

   // ordering with fillers as +inf in ascending order and -inf in descending order
   function automatic logic elem_less(elem_type a, elem_type b, logic ascending);
      logic res;
      if (a.pad && b.pad) begin
         res = 1'b0;
      end else if (a.pad != b.pad) begin
         res = ascending ? b.pad : a.pad;
      end else begin
         res = (a.value < b.value);
      end
      return res;
   endfunction

endpackage

FILE: sv/bitonic_sorter_core.sv
// bitonic sorter: collects a set of signed values, sorts them on one shared
// compare-exchange unit and streams them out in order
// depends on bs_pkg, bs_ram, bs_cmp_xchg and bitonic_sorter_core_macros.svh
//
// usage:
//   req_ channel: one value per item, req_last_value closes the set. An item
//   that fills the store to MAX_ELEMENTS closes the set as well.
//   rsp_ channel: the sorted set, one value per item, rsp_last_result on the
//   final one. csr_ channel: sort_ascending (1 ascending, 0 descending),
//   always ready, sampled when the closing item arrives.
// sequence for a set: the items are loaded as they arrive, then filler writes
//   pad the store up to the next power of two, then the passes run on the
//   compare-exchange unit (one pair per cycle, one bank per index parity, an
//   idle gap state between passes), then each result is read out once the one
//   before it is taken. A set of one value goes straight to output.
// req_stall stays high from the closing item until the final result is taken.
// a stall on rsp_ holds the current result; the sequencer waits on it.
// reset: synchronous, empties the set, selects ascending, drops rsp_valid.
`include "bitonic_sorter_core_macros.svh"

module bitonic_sorter_core #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bs_pkg::VALUE_W-1:0]     req_value,
   input  logic                                  req_last_value,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bs_pkg::VALUE_W-1:0]     rsp_sorted_value,
   output logic                                  rsp_last_result,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_sort_ascending
);

   localparam int IDX_W      = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int SZ_W       = IDX_W + 1;
   localparam int ADDR_W     = (IDX_W > 1) ? IDX_W - 1 : 1;
   localparam int BANK_DEPTH = 2 ** ADDR_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_PAD       = 3'd1;
   localparam logic [2:0] ST_SORT      = 3'd2;
   localparam logic [2:0] ST_GAP       = 3'd3;
   localparam logic [2:0] ST_EMIT_RD   = 3'd4;
   localparam logic [2:0] ST_EMIT_WAIT = 3'd5;
   localparam logic [2:0] ST_EMIT_HOLD = 3'd6;

   // smallest power of two not below n, one-hot
   function automatic logic [SZ_W-1:0] pow2_ceil(logic [SZ_W-1:0] n);
      logic [SZ_W-1:0] res;
      res = '0;
      for (int b = SZ_W - 1; b >= 0; b--) begin
         if ((SZ_W'(1) << b) >= n) begin
            res = SZ_W'(1) << b;
         end
      end
      return res;
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [SZ_W-1:0]         count_ff, count_in;
   logic [SZ_W-1:0]         size_ff, size_in;
   logic [SZ_W-1:0]         pad_idx_ff, pad_idx_in;
   logic [SZ_W-1:0]         k_ff, k_in;
   logic [IDX_W-1:0]        j_ff, j_in;
   logic [IDX_W-1:0]        pair_ff, pair_in;
   logic                    done_ff, done_in;
   logic                    asc_cfg_ff;
   logic                    asc_ff, asc_in;
   logic [IDX_W-1:0]        emit_idx_ff, emit_idx_in;
   logic                    s2_valid_ff;
   logic                    s2_par_ff;
   logic [ADDR_W-1:0]       s2_addr_i_ff, s2_addr_l_ff;
   logic                    s2_up_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [bs_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_accept;
   logic                    rsp_accept;
   logic [SZ_W-1:0]         n_new;
   logic                    set_closed;
   logic [IDX_W-1:0]        pair_mask;
   logic [IDX_W-1:0]        pair_i, pair_l;
   logic                    pair_par_i, pair_par_l;
   logic                    pair_up;
   logic                    last_pair;
   logic [IDX_W-1:0]        emit_next;
   logic [IDX_W-1:0]        load_idx;
   logic [IDX_W-1:0]        pad_idx;

   logic                    wr_en   [2];
   logic [ADDR_W-1:0]       wr_addr [2];
   bs_pkg::elem_type        wr_data [2];
   logic                    rd_en   [2];
   logic [ADDR_W-1:0]       rd_addr [2];
   logic [bs_pkg::ELEM_W-1:0] rd_raw [2];
   bs_pkg::elem_type        rd_data [2];

   bs_pkg::elem_type        xchg_lo, xchg_hi;
   bs_pkg::elem_type        new_lo, new_hi;
   bs_pkg::xchg_ctrl_type   xchg_ctrl;

   // handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   assign n_new      = count_ff + SZ_W'(1);
   assign set_closed = req_last_value || (n_new == SZ_W'(MAX_ELEMENTS));
   assign load_idx   = count_ff[IDX_W-1:0];
   assign pad_idx    = pad_idx_ff[IDX_W-1:0];
   assign emit_next  = emit_idx_ff + IDX_W'(1);

   // pair of the current pass: insert a zero at the stride bit of the pair number
   assign pair_mask  = j_ff - IDX_W'(1);
   assign pair_i     = IDX_W'({pair_ff & ~pair_mask, 1'b0}) | (pair_ff & pair_mask);
   assign pair_l     = pair_i | j_ff;
   assign pair_par_i = ^pair_i;
   assign pair_par_l = ^pair_l;
   assign pair_up    = ((SZ_W'(pair_i) & k_ff) == '0) == asc_ff;
   assign last_pair  = (pair_ff + IDX_W'(1)) == IDX_W'(size_ff >> 1);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      size_in     = size_ff;
      pad_idx_in  = pad_idx_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      pair_in     = pair_ff;
      done_in     = done_ff;
      asc_in      = asc_ff;
      emit_idx_in = emit_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               count_in = n_new;
               if (set_closed) begin
                  asc_in      = asc_cfg_ff;
                  emit_idx_in = '0;
                  size_in     = pow2_ceil(n_new);
                  pad_idx_in  = n_new;
                  state_in    = (count_ff == '0) ? ST_EMIT_RD : ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_idx_ff == size_ff) begin
               k_in     = SZ_W'(2);
               j_in     = IDX_W'(1);
               pair_in  = '0;
               done_in  = 1'b0;
               state_in = ST_SORT;
            end else begin
               pad_idx_in = pad_idx_ff + SZ_W'(1);
            end
         end
         ST_SORT: begin
            if (last_pair) begin
               pair_in  = '0;
               state_in = ST_GAP;
               if (j_ff == IDX_W'(1)) begin
                  if (k_ff == size_ff) begin
                     done_in = 1'b1;
                  end else begin
                     k_in = k_ff << 1;
                     j_in = k_ff[IDX_W-1:0];
                  end
               end else begin
                  j_in = j_ff >> 1;
               end
            end else begin
               pair_in = pair_ff + IDX_W'(1);
            end
         end
         ST_GAP: begin
            emit_idx_in = '0;
            state_in    = done_ff ? ST_EMIT_RD : ST_SORT;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            state_in = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_accept) begin
               if (rsp_last_ff) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_next;
                  state_in    = ST_EMIT_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (state_ff == ST_EMIT_WAIT) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = rd_data[^emit_idx_ff].value;
         rsp_last_in  = (SZ_W'(emit_idx_ff) + SZ_W'(1)) == count_ff;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   // bank write ports: load, filler, or compare-exchange write-back
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         wr_en[b]   = 1'b0;
         wr_addr[b] = '0;
         wr_data[b] = '0;
      end
      if (s2_valid_ff) begin
         for (int b = 0; b < 2; b++) begin
            wr_en[b] = 1'b1;
         end
         wr_addr[s2_par_ff]  = s2_addr_i_ff;
         wr_data[s2_par_ff]  = new_lo;
         wr_addr[!s2_par_ff] = s2_addr_l_ff;
         wr_data[!s2_par_ff] = new_hi;
      end else if (req_accept) begin
         wr_en[^load_idx]         = 1'b1;
         wr_addr[^load_idx]       = ADDR_W'(load_idx >> 1);
         wr_data[^load_idx].pad   = 1'b0;
         wr_data[^load_idx].value = req_value;
      end else if ((state_ff == ST_PAD) && (pad_idx_ff != size_ff)) begin
         wr_en[^pad_idx]       = 1'b1;
         wr_addr[^pad_idx]     = ADDR_W'(pad_idx >> 1);
         wr_data[^pad_idx].pad = 1'b1;
      end
   end

   // bank read ports: pair fetch or output fetch
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         rd_en[b]   = 1'b0;
         rd_addr[b] = '0;
      end
      if (state_ff == ST_SORT) begin
         rd_en[pair_par_i]   = 1'b1;
         rd_addr[pair_par_i] = ADDR_W'(pair_i >> 1);
         rd_en[pair_par_l]   = 1'b1;
         rd_addr[pair_par_l] = ADDR_W'(pair_l >> 1);
      end else if (state_ff == ST_EMIT_RD) begin
         for (int b = 0; b < 2; b++) begin
            rd_en[b]   = 1'b1;
            rd_addr[b] = ADDR_W'(emit_idx_ff >> 1);
         end
      end else if ((state_ff == ST_EMIT_HOLD) && rsp_accept && !rsp_last_ff) begin
         for (int b = 0; b < 2; b++) begin
            rd_en[b]   = 1'b1;
            rd_addr[b] = ADDR_W'(emit_next >> 1);
         end
      end
   end

   // element store, split by index parity so both ends of a pair are read together
   for (genvar b = 0; b < 2; b++) begin : g_bank
      bs_ram #(
         .WIDTH (bs_pkg::ELEM_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_addr[b]),
         .wr_data (wr_data[b]),
         .rd_en   (rd_en[b]),
         .rd_addr (rd_addr[b]),
         .rd_data (rd_raw[b])
      );
      assign rd_data[b] = bs_pkg::elem_type'(rd_raw[b]);
   end

   // shared compare-exchange on the fetched pair
   assign xchg_lo             = rd_data[s2_par_ff];
   assign xchg_hi             = rd_data[!s2_par_ff];
   assign xchg_ctrl.up        = s2_up_ff;
   assign xchg_ctrl.ascending = asc_ff;

   bs_cmp_xchg u_cmp (
      .elem_lo (xchg_lo),
      .elem_hi (xchg_hi),
      .ctrl    (xchg_ctrl),
      .out_lo  (new_lo),
      .out_hi  (new_hi)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         asc_cfg_ff   <= 1'b1;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         s2_valid_ff  <= (state_ff == ST_SORT);
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         if (csr_valid && csr_ready) begin
            asc_cfg_ff <= csr_sort_ascending;
         end
      end
   end

   // sequencer counters and payload
   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      pad_idx_ff   <= pad_idx_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      pair_ff      <= pair_in;
      asc_ff       <= asc_in;
      emit_idx_ff  <= emit_idx_in;
      s2_par_ff    <= pair_par_i;
      s2_addr_i_ff <= ADDR_W'(pair_i >> 1);
      s2_addr_l_ff <= ADDR_W'(pair_l >> 1);
      s2_up_ff     <= pair_up;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_result  = rsp_last_ff;

   // checks
   `BSC_ASSERT_IMPLY(a_pair_banks, state_ff == ST_SORT, pair_par_i != pair_par_l, "pair in one bank")
   `BSC_ASSERT_IMPLY(a_rsp_hold, rsp_valid_ff, state_ff == ST_EMIT_HOLD, "result outside hold")
   `BSC_ASSERT_IMPLY(a_idle_count, state_ff == ST_IDLE, count_ff < SZ_W'(MAX_ELEMENTS), "store overrun")
   `BSC_ASSERT_NEXT(a_gap_bubble, state_ff == ST_GAP, !s2_valid_ff, "no bubble between passes")

endmodule

FILE: sv/bs_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module bs_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bs_cmp_xchg.sv
// shared compare-exchange unit of the bitonic sorter
// depends on bs_pkg
module bs_cmp_xchg (
   input  bs_pkg::elem_type      elem_lo,
   input  bs_pkg::elem_type      elem_hi,
   input  bs_pkg::xchg_ctrl_type ctrl,
   output bs_pkg::elem_type      out_lo,
   output bs_pkg::elem_type      out_hi
);

   logic swap;

   // exchange when the pair is out of order for this block's direction
   always_comb begin
      if (ctrl.up) begin
         swap = bs_pkg::elem_less(elem_hi, elem_lo, ctrl.ascending);
      end else begin
         swap = bs_pkg::elem_less(elem_lo, elem_hi, ctrl.ascending);
      end
   end

   assign out_lo = swap ? elem_hi : elem_lo;
   assign out_hi = swap ? elem_lo : elem_hi;

endmodule

FILE: sim/tb_bitonic_sorter_core.sv
// testbench for bitonic_sorter_core: sends sets of signed values, predicts each
// sorted set and checks every result item in order
// depends on bs_pkg and the bitonic_sorter_core rtl
module tb_bitonic_sorter_core;

   localparam int MAX_ELEMENTS   = 64;
   localparam int RANDOM_ITEMS   = 60;
   localparam int PRESSURE_SET   = 16;
   localparam int STALL_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_HOLD      = 400;

   typedef logic signed [bs_pkg::VALUE_W-1:0] value_type;
   typedef value_type value_list_type[$];

   typedef struct {
      value_type value;
      logic      last;
   } sorted_item_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   value_type req_value;
   logic      req_last_value;
   logic      rsp_valid;
   logic      rsp_stall;
   value_type rsp_sorted_value;
   logic      rsp_last_result;
   logic      csr_valid;
   logic      csr_ready;
   logic      csr_sort_ascending;

   // predictor state: the set being collected and the selected direction
   value_type       model_set[MAX_ELEMENTS];
   int              model_count = 0;
   bit              model_ascending = 1'b1;
   sorted_item_type expected_sorted[$];

   int  err_count = 0;
   int  quiet_cycles = 0;
   bit  req_no_gaps = 1'b0;
   bit  rsp_no_stalls = 1'b0;
   int  rsp_hold_cycles = 0;

   bitonic_sorter_core #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value          (req_value),
      .req_last_value     (req_last_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sorted_value   (rsp_sorted_value),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_sort_ascending (csr_sort_ascending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // merge a bitonic span, stride is the largest power of two below its length
   function automatic void merge_span(bit up, int lo, int hi);
      int        stride;
      int        i;
      value_type tmp;
      if (hi <= lo + 1) return;
      stride = 1;
      if (hi - lo - 1 <= 2) begin
         stride = hi - lo - 1;
      end else begin
         while (stride * 2 <= hi - lo - 1) stride = stride * 2;
      end
      for (i = lo; i < hi - stride; i++) begin
         if ((model_set[i] < model_set[i + stride]) ^ up) begin
            tmp                   = model_set[i];
            model_set[i]          = model_set[i + stride];
            model_set[i + stride] = tmp;
         end
      end
      merge_span(up, lo, lo + stride);
      merge_span(up, lo + stride, hi);
   endfunction

   // lower half against the final direction, upper half along it, then merge
   function automatic void sort_span(bit up, int lo, int hi);
      int mid;
      mid = (lo + hi) / 2;
      if (mid == lo) return;
      sort_span(!up, lo, mid);
      sort_span(up, mid, hi);
      merge_span(up, lo, hi);
   endfunction

   // collect one accepted item; a closing item or a full store releases the set
   function automatic void collect_item(value_type v, logic lst);
      sorted_item_type res;
      model_set[model_count] = v;
      model_count++;
      if (lst || model_count == MAX_ELEMENTS) begin
         if (model_count > 1) sort_span(model_ascending, 0, model_count);
         for (int k = 0; k < model_count; k++) begin
            res.value = model_set[k];
            res.last  = (k == model_count - 1);
            expected_sorted.push_back(res);
         end
         model_count = 0;
      end
   endfunction

   // mix of full range values, a narrow band with repeats, the extremes, zero and minus one
   function automatic value_type rand_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return $urandom;
      if (pick < 8) return $signed($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 3))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0000_0000;
         default: return 32'shffff_ffff;
      endcase
   endfunction

   // offer one item after a random gap, unless gaps are off, and hold it until accepted
   task automatic send_item(value_type v, logic lst);
      int gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= v;
      req_last_value <= lst;
      do @(posedge clock); while (req_stall);
      collect_item(v, lst);
   endtask

   task automatic send_list(value_list_type vals);
      foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
   endtask

   task automatic send_set(int n, bit close_set);
      for (int k = 0; k < n; k++) send_item(rand_value(), close_set && (k == n - 1));
   endtask

   // drop valid, wait for every expected result, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only issued with the block idle
   task automatic write_direction(bit ascending);
      wait_idle();
      csr_valid          <= 1'b1;
      csr_sort_ascending <= ascending;
      do @(posedge clock); while (!csr_ready);
      model_ascending = ascending;
      csr_valid <= 1'b0;
   endtask

   // single values, extremes, repeats and both directions
   task automatic test_corner_sets();
      value_list_type vals;
      write_direction(1'b1);
      vals = {32'sh8000_0000};
      send_list(vals);
      vals = {32'sh7fff_ffff};
      send_list(vals);
      vals = {32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'shffff_ffff, 32'sh1};
      send_list(vals);
      vals = {32'sh5, 32'sh5, -32'sh5, 32'sh5};
      send_list(vals);
      write_direction(1'b0);
      vals = {32'sh8000_0000, 32'sh7fff_ffff, 32'sh7, 32'sh7, -32'sh3,
              32'sh5555_5555, 32'shaaaa_aaaa};
      send_list(vals);
      vals = {-32'sh1, 32'sh1};
      send_list(vals);
      vals = {32'sh1234_5678};
      send_list(vals);
   endtask

   // a full store closes the set on its own and collection starts afresh
   task automatic test_full_store();
      write_direction(1'b0);
      send_set(MAX_ELEMENTS, 1'b0);
      send_set(3, 1'b1);
   endtask

   // receiver holds off while the sender keeps offering the next set
   task automatic test_backpressure();
      write_direction(1'b1);
      req_no_gaps     = 1'b1;
      rsp_hold_cycles = LONG_HOLD;
      send_set(PRESSURE_SET, 1'b1);
      send_set(5, 1'b1);
      req_no_gaps = 1'b0;
   endtask

   // random sets, mostly short, with occasional direction changes
   task automatic test_random_sets();
      int  sent;
      int  n;
      int  pick;
      bit  close_set;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) write_direction(1'($urandom_range(0, 1)));
         req_no_gaps   = ($urandom_range(0, 3) == 0);
         rsp_no_stalls = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) n = $urandom_range(1, 8);
         else if (pick < 9) n = $urandom_range(9, 24);
         else n = $urandom_range(25, MAX_ELEMENTS);
         close_set = (n < MAX_ELEMENTS) ? 1'b1 : 1'($urandom_range(0, 1));
         send_set(n, close_set);
         sent += n;
      end
      req_no_gaps   = 1'b0;
      rsp_no_stalls = 1'b0;
   endtask

   // result side: random stalls (off on request, or one long hold), compare each item with the oldest expectation
   initial begin : result_monitor
      int              n;
      sorted_item_type want;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         n = rsp_no_stalls ? 0 : $urandom_range(0, 8);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         if (expected_sorted.size() == 0) begin
            $error("result item with none expected: sorted_value %0d", rsp_sorted_value);
            err_count++;
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_sorted_value !== want.value) begin
               $error("sorted_value: expected %0d, got %0d", want.value, rsp_sorted_value);
               err_count++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %0b, got %0b", want.last, rsp_last_result);
               err_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_value          <= '0;
      req_last_value     <= 1'b0;
      csr_valid          <= 1'b0;
      csr_sort_ascending <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_sets();
      test_full_store();
      test_backpressure();
      test_random_sets();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: bitonic_sorter_core.f
+incdir+sv
sv/bs_pkg.sv
sv/bs_ram.sv
sv/bs_cmp_xchg.sv
sv/bitonic_sorter_core.sv
sim/tb_bitonic_sorter_core.sv
